>>> src/lrt_pkg.sv
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types, field widths and codes for the longest-prefix-match route table.
// ----------------------------------------------------------------------------
`default_nettype none

package lrt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int HOP_W  = 32;
    localparam int PORT_W = 8;
    localparam int OP_W   = 2;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    localparam int CMD_FIFO_DEPTH = 2;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_INSERT,
        KIND_DELETE,
        KIND_LOOKUP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  address;
        logic [LEN_W-1:0]   prefix_len;
        logic [HOP_W-1:0]   next_hop;
        logic [PORT_W-1:0]  port;
    } cmd_t;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  prefix;
        logic [LEN_W-1:0]   length;
        logic [HOP_W-1:0]   next_hop;
        logic [PORT_W-1:0]  port;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // keeps the top len bits of an address, len in 0..32
    function automatic logic [ADDR_W-1:0] top_mask(input logic [LEN_W-1:0] len);
        top_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

`default_nettype wire

>>> src/lrt_ram.sv
// ----------------------------------------------------------------------------
// lrt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lrt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/lrt_front.sv
// ----------------------------------------------------------------------------
// lrt_front
// Accepts transactions, decodes the operation and queues commands for the
// scan engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lrt_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // address, prefix_len, next_hop_in, port_in, zero pad
    input  wire logic [lrt_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode
    input  wire logic [lrt_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                           clear_busy,
    output      logic                           cmd_valid,
    output      lrt_pkg::cmd_t                  cmd,
    input  wire logic                           cmd_pop
);

    import lrt_pkg::*;

    localparam int ADDR_LO = 0;
    localparam int LEN_LO  = ADDR_LO + ADDR_W;
    localparam int HOP_LO  = LEN_LO + LEN_W;
    localparam int PORT_LO = HOP_LO + HOP_W;
    localparam int PTR_W   = $clog2(CMD_FIFO_DEPTH);
    localparam int CNT_W   = $clog2(CMD_FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMD_FIFO_DEPTH);

    cmd_t             cmd_in;
    logic             len_ok;
    logic             push;
    cmd_t             fifo_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        cmd_in.address    = s_tdata[ADDR_LO +: ADDR_W];
        cmd_in.prefix_len = s_tdata[LEN_LO +: LEN_W];
        cmd_in.next_hop   = s_tdata[HOP_LO +: HOP_W];
        cmd_in.port       = s_tdata[PORT_LO +: PORT_W];
        len_ok            = (cmd_in.prefix_len <= MAX_LEN);
        case (s_tuser)
            OP_INSERT: begin
                cmd_in.kind = len_ok ? KIND_INSERT : KIND_NOP;
            end
            OP_DELETE: begin
                cmd_in.kind = len_ok ? KIND_DELETE : KIND_NOP;
            end
            OP_LOOKUP: begin
                cmd_in.kind = KIND_LOOKUP;
            end
            default: begin
                cmd_in.kind = KIND_NOP;
            end
        endcase
    end

    assign s_tready  = (count_reg != FULL_CNT) && !clear_busy;
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (cmd_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && cmd_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

>>> src/lrt_back.sv
// ----------------------------------------------------------------------------
// lrt_back
// Scan engine: walks every table slot once per command other than a NOP, then
// updates the table for an insert or delete and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrt_back #(
    parameter int TABLE_DEPTH = lrt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cmd_valid,
    input  wire lrt_pkg::cmd_t                  cmd,
    output      logic                           cmd_pop,
    output      logic                           clear_busy,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // next_hop_out, out_port
    output      logic [lrt_pkg::M_TDATA_W-1:0]  m_tdata,
    // hit, table_full
    output      logic [lrt_pkg::M_TUSER_W-1:0]  m_tuser
);

    import lrt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    cmd_t               op_reg, op_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;

    logic               key_found_reg, key_found_next;
    logic [IDX_W-1:0]   key_idx_reg, key_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic               best_found_reg, best_found_next;
    logic [LEN_W-1:0]   best_len_reg, best_len_next;
    logic [HOP_W-1:0]   best_hop_reg, best_hop_next;
    logic [PORT_W-1:0]  best_port_reg, best_port_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic               hit_reg, hit_next;
    logic               full_reg, full_next;
    logic [HOP_W-1:0]   hop_out_reg, hop_out_next;
    logic [PORT_W-1:0]  port_out_reg, port_out_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    slot_t              wr_data;
    slot_t              rd_data;
    logic               key_match;
    logic               route_match;

    lrt_ram #(
        .DATA_W (SLOT_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    assign key_match = rd_data.valid && (rd_data.prefix == op_reg.address) &&
                       (rd_data.length == op_reg.prefix_len);
    assign route_match = rd_data.valid && (rd_data.length <= MAX_LEN) &&
                         ((op_reg.address & top_mask(rd_data.length)) == rd_data.prefix);

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        rd_valid_next   = (state_reg == S_SCAN);
        rd_idx_next     = cnt_reg;
        key_found_next  = key_found_reg;
        key_idx_next    = key_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_len_next   = best_len_reg;
        best_hop_next   = best_hop_reg;
        best_port_next  = best_port_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        hit_next        = hit_reg;
        full_next       = full_reg;
        hop_out_next    = hop_out_reg;
        port_out_next   = port_out_reg;
        cmd_pop         = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg;
        wr_data         = '0;

        // per-slot compare on the data read in the previous cycle
        if (rd_valid_reg) begin
            if (key_match && !key_found_reg) begin
                key_found_next = 1'b1;
                key_idx_next   = rd_idx_reg;
            end
            if (!rd_data.valid && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = rd_idx_reg;
            end
            if (route_match && (!best_found_reg || rd_data.length > best_len_reg)) begin
                best_found_next = 1'b1;
                best_len_next   = rd_data.length;
                best_hop_next   = rd_data.next_hop;
                best_port_next  = rd_data.port;
            end
        end

        case (state_reg)
            S_CLEAR: begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop         = 1'b1;
                    op_next         = cmd;
                    cnt_next        = '0;
                    key_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    best_found_next = 1'b0;
                    state_next      = (cmd.kind == KIND_NOP) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    hit_next      = 1'b0;
                    full_next     = 1'b0;
                    hop_out_next  = '0;
                    port_out_next = '0;
                    state_next    = S_IDLE;
                    case (op_reg.kind)
                        KIND_INSERT: begin
                            wr_data.valid    = 1'b1;
                            wr_data.prefix   = op_reg.address;
                            wr_data.length   = op_reg.prefix_len;
                            wr_data.next_hop = op_reg.next_hop;
                            wr_data.port     = op_reg.port;
                            if (key_found_reg) begin
                                wr_en   = 1'b1;
                                wr_addr = key_idx_reg;
                            end else if (free_found_reg) begin
                                wr_en   = 1'b1;
                                wr_addr = free_idx_reg;
                            end else begin
                                full_next = 1'b1;
                            end
                        end
                        KIND_DELETE: begin
                            if (key_found_reg) begin
                                wr_en    = 1'b1;
                                wr_addr  = key_idx_reg;
                                hit_next = 1'b1;
                            end
                        end
                        KIND_LOOKUP: begin
                            if (best_found_reg) begin
                                hit_next      = 1'b1;
                                hop_out_next  = best_hop_reg;
                                port_out_next = best_port_reg;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            key_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_valid_reg   <= rd_valid_next;
            key_found_reg  <= key_found_next;
            free_found_reg <= free_found_next;
            best_found_reg <= best_found_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        op_reg        <= op_next;
        rd_idx_reg    <= rd_idx_next;
        key_idx_reg   <= key_idx_next;
        free_idx_reg  <= free_idx_next;
        best_len_reg  <= best_len_next;
        best_hop_reg  <= best_hop_next;
        best_port_reg <= best_port_next;
        hit_reg       <= hit_next;
        full_reg      <= full_next;
        hop_out_reg   <= hop_out_next;
        port_out_reg  <= port_out_next;
    end

    assign clear_busy = (state_reg == S_CLEAR);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {port_out_reg, hop_out_reg};
    assign m_tuser    = {full_reg, hit_reg};

    a_full_not_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("table_full and hit both set");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("nonzero next hop or port without a hit");

    a_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !cmd_pop)
        else $error("command taken during clearing pass");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |=> !cmd_pop)
        else $error("second command taken while one is in progress");

    a_no_write_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN || state_reg == S_DRAIN) |-> !wr_en)
        else $error("table written during scan");

endmodule

`default_nettype wire

>>> src/lpm_route_table.sv
// ----------------------------------------------------------------------------
// lpm_route_table
// IPv4 route table with insert, delete and longest-prefix-match lookup.
// operations are handled one at a time by a slot scan that reads one table
// slot per cycle from the single read port; a two-entry command queue accepts
// new transactions while a scan runs, until the queue is full
// reset: after aresetn a clearing pass empties the table and s_tready stays
// low until it ends
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_route_table #(
    parameter int TABLE_DEPTH = lrt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // address, prefix_len, next_hop_in, port_in, zero pad
    input  wire logic [lrt_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode
    input  wire logic [lrt_pkg::S_TUSER_W-1:0]  s_tuser,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // next_hop_out, out_port
    output      logic [lrt_pkg::M_TDATA_W-1:0]  m_tdata,
    // hit, table_full
    output      logic [lrt_pkg::M_TUSER_W-1:0]  m_tuser
);

    import lrt_pkg::*;

    logic clear_busy;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    lrt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .clear_busy (clear_busy),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    lrt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

>>> sim/lpm_route_table_tb.sv
// ----------------------------------------------------------------------------
// lpm_route_table_tb
// Self-checking bench for the longest-prefix-match route table. A short
// directed table covers reset state, default and host routes, replace,
// prefixes with host bits, bad lengths and the unused opcode. Random traffic
// follows: an insert-heavy stretch that fills the table past capacity, then a
// mix of deletes, inserts and lookups aimed at stored routes. Results are
// checked against a behavioral route table kept in the bench, or a typed row.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_route_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = lrt_pkg::TABLE_DEPTH_DEF;
    localparam int LATENCY      = DEPTH + 4;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic        hit;
        logic        full;
        logic [31:0] hop;
        logic [7:0]  port;
    } route_result_t;

    typedef struct packed {
        logic [1:0]    op;
        logic [31:0]   addr;
        logic [5:0]    len;
        logic [31:0]   hop;
        logic [7:0]    port;
        logic          typed;
        route_result_t res;
    } plan_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // address, prefix_len, next_hop_in, port_in, zero pad
    logic [79:0] s_tdata  = '0;
    // opcode
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // next_hop_out, out_port
    logic [39:0] m_tdata;
    // hit, table_full
    logic [1:0]  m_tuser;

    route_result_t route_q[$];
    plan_row_t     plan[$];
    int            errors = 0;
    int            cycles = 0;
    logic          quiet  = 1'b0;

    logic        rt_valid [DEPTH];
    logic [31:0] rt_prefix[DEPTH];
    logic [5:0]  rt_len   [DEPTH];
    logic [31:0] rt_hop   [DEPTH];
    logic [7:0]  rt_port  [DEPTH];
    logic [31:0] bases    [16];

    lpm_route_table #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("lpm_route_table test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 30);
    end

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        if (len == 6'd0)
            return 32'h0;
        return 32'hFFFF_FFFF << (6'd32 - len);
    endfunction

    // updates the bench route table and returns the expected result
    function automatic route_result_t route_apply(input logic [1:0] op,
            input logic [31:0] addr, input logic [5:0] len,
            input logic [31:0] hop, input logic [7:0] port);
        route_result_t r;
        int slot;
        int best;
        r    = '0;
        slot = -1;
        best = -1;
        if (op == lrt_pkg::OP_INSERT && len <= 6'd32) begin
            for (int i = 0; i < DEPTH; i++)
                if (slot < 0 && rt_valid[i] && rt_prefix[i] == addr && rt_len[i] == len)
                    slot = i;
            for (int i = 0; i < DEPTH; i++)
                if (slot < 0 && !rt_valid[i])
                    slot = i;
            if (slot < 0) begin
                r.full = 1'b1;
            end else begin
                rt_valid[slot]  = 1'b1;
                rt_prefix[slot] = addr;
                rt_len[slot]    = len;
                rt_hop[slot]    = hop;
                rt_port[slot]   = port;
            end
        end else if (op == lrt_pkg::OP_DELETE && len <= 6'd32) begin
            for (int i = 0; i < DEPTH; i++)
                if (slot < 0 && rt_valid[i] && rt_prefix[i] == addr && rt_len[i] == len)
                    slot = i;
            if (slot >= 0) begin
                rt_valid[slot] = 1'b0;
                r.hit = 1'b1;
            end
        end else if (op == lrt_pkg::OP_LOOKUP) begin
            for (int i = 0; i < DEPTH; i++)
                if (rt_valid[i] && rt_len[i] <= 6'd32
                        && (addr & prefix_mask(rt_len[i])) == rt_prefix[i]
                        && (best < 0 || rt_len[i] > rt_len[best]))
                    best = i;
            if (best >= 0) begin
                r.hit  = 1'b1;
                r.hop  = rt_hop[best];
                r.port = rt_port[best];
            end
        end
        return r;
    endfunction

    function automatic int pick_live_slot();
        int idx;
        int start;
        idx   = -1;
        start = $urandom_range(DEPTH - 1);
        for (int k = 0; k < DEPTH; k++)
            if (idx < 0 && rt_valid[(start + k) % DEPTH])
                idx = (start + k) % DEPTH;
        return idx;
    endfunction

    task automatic random_key(output logic [31:0] addr, output logic [5:0] len);
        logic [31:0] base;
        base = bases[$urandom_range(15)];
        if ($urandom_range(9) == 0)
            len = $urandom_range(1) ? 6'd0 : 6'd32;
        else
            len = 6'($urandom_range(32));
        addr = base & prefix_mask(len);
        // now and then keep host bits below the length
        if ($urandom_range(19) == 0)
            addr = base;
    endtask

    task automatic add_row(input logic [1:0] op, input logic [31:0] addr,
            input logic [5:0] len, input logic [31:0] hop, input logic [7:0] port,
            input logic typed, input logic hit, input logic full,
            input logic [31:0] rhop, input logic [7:0] rport);
        plan_row_t row;
        row.op    = op;
        row.addr  = addr;
        row.len   = len;
        row.hop   = hop;
        row.port  = port;
        row.typed = typed;
        row.res   = '{hit, full, rhop, rport};
        plan.push_back(row);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
            input logic [5:0] len, input logic [31:0] hop, input logic [7:0] port,
            input logic typed, input route_result_t typed_res);
        route_result_t r;
        int gap;
        gap = 0;
        if (!quiet) begin
            if ($urandom_range(9) == 0)
                gap = $urandom_range(80, 1);
            else
                while ($urandom_range(99) < 30)
                    gap++;
        end
        repeat (gap) begin
            s_tvalid <= 1'b0;
            s_tuser  <= 2'($urandom);
            s_tdata  <= 80'({$urandom, $urandom, $urandom});
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, port, hop, len, addr};
        do
            @(posedge aclk);
        while (!s_tready);
        r = route_apply(op, addr, len, hop, port);
        if (typed)
            r = typed_res;
        route_q.push_back(r);
    endtask

    always @(posedge aclk) begin : check_results
        route_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (route_q.size() == 0) begin
                $error("result transaction with no expected result");
                errors++;
            end else begin
                want = route_q.pop_front();
                if (m_tuser[0] !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== want.full) begin
                    $error("table_full: expected %0d, got %0d", want.full, m_tuser[1]);
                    errors++;
                end
                if (m_tdata[31:0] !== want.hop) begin
                    $error("next_hop_out: expected %h, got %h", want.hop, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[39:32] !== want.port) begin
                    $error("out_port: expected %0d, got %0d", want.port, m_tdata[39:32]);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [1:0]  g_op;
        logic [31:0] g_addr;
        logic [31:0] g_hop;
        logic [31:0] m;
        logic [5:0]  g_len;
        logic [7:0]  g_port;
        int          pick;
        int          idx;

        for (int i = 0; i < DEPTH; i++)
            rt_valid[i] = 1'b0;
        for (int i = 0; i < 16; i++)
            bases[i] = $urandom;

        // op, address, length, next hop, port, typed, hit, full, hop, port
        add_row(lrt_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0, 8'h0, 1, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_DELETE, 32'h0000_0000, 6'd0, 32'h0, 8'h0, 1, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_INSERT, 32'h0000_0000, 6'd0, 32'hFFFF_FFFF, 8'hFF,
                1, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'h0,
                1, 1, 0, 32'hFFFF_FFFF, 8'hFF);
        add_row(lrt_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'h0102_0304, 8'h01,
                1, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'h0, 0, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 6'd0, 32'h0, 8'h0, 0, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_INSERT, 32'h0A00_0000, 6'd8, 32'h0A00_00FE, 8'd10,
                0, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_INSERT, 32'h0A01_0000, 6'd16, 32'h0A01_00FE, 8'd11,
                0, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0, 8'h0, 0, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_LOOKUP, 32'h0A02_0304, 6'd0, 32'h0, 8'h0, 0, 0, 0, 32'h0, 8'h0);
        // same key again replaces the route
        add_row(lrt_pkg::OP_INSERT, 32'h0A00_0000, 6'd8, 32'h5555_AAAA, 8'h80,
                0, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_LOOKUP, 32'h0A02_0304, 6'd0, 32'h0, 8'h0, 0, 0, 0, 32'h0, 8'h0);
        // prefix with host bits never matches but is still a key
        add_row(lrt_pkg::OP_INSERT, 32'hC0A8_0101, 6'd16, 32'hAAAA_5555, 8'h7F,
                0, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_LOOKUP, 32'hC0A8_0101, 6'd0, 32'h0, 8'h0, 0, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_DELETE, 32'hC0A8_0101, 6'd16, 32'h0, 8'h0, 0, 0, 0, 32'h0, 8'h0);
        // lengths above 32 and the unused opcode are ignored
        add_row(lrt_pkg::OP_INSERT, 32'h0B00_0000, 6'd33, 32'h1234_5678, 8'h12,
                1, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF,
                1, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_DELETE, 32'h0A00_0000, 6'd40, 32'h0, 8'h0, 1, 0, 0, 32'h0, 8'h0);
        add_row(OP_UNUSED, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF, 1, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_DELETE, 32'h0000_0000, 6'd0, 32'h0, 8'h0, 0, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_LOOKUP, 32'h1234_5678, 6'd0, 32'h0, 8'h0, 0, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_DELETE, 32'hFFFF_FFFF, 6'd32, 32'h0, 8'h0, 0, 0, 0, 32'h0, 8'h0);
        add_row(lrt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'h0, 0, 0, 0, 32'h0, 8'h0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i])
            send_item(plan[i].op, plan[i].addr, plan[i].len, plan[i].hop, plan[i].port,
                      plan[i].typed, plan[i].res);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet  = (n >= 300 && n < 360);
            pick   = $urandom_range(99);
            g_hop  = $urandom;
            g_port = 8'($urandom);
            g_len  = 6'd0;
            // first stretch fills the table past capacity
            if (n < 200)
                pick = (pick < 70) ? pick / 3 : pick;
            if (pick >= 95) begin
                g_addr = $urandom;
                if ($urandom_range(1)) begin
                    g_op  = OP_UNUSED;
                    g_len = 6'($urandom);
                end else begin
                    g_op  = $urandom_range(1) ? lrt_pkg::OP_INSERT : lrt_pkg::OP_DELETE;
                    g_len = 6'($urandom_range(63, 33));
                end
            end else if (pick < 25) begin
                g_op = lrt_pkg::OP_INSERT;
                random_key(g_addr, g_len);
            end else if (pick < 60) begin
                g_op = lrt_pkg::OP_DELETE;
                idx  = pick_live_slot();
                if (idx >= 0 && $urandom_range(4) != 0) begin
                    g_addr = rt_prefix[idx];
                    g_len  = rt_len[idx];
                end else begin
                    random_key(g_addr, g_len);
                end
            end else begin
                g_op = lrt_pkg::OP_LOOKUP;
                idx  = pick_live_slot();
                if (idx >= 0 && $urandom_range(3) != 0) begin
                    m      = prefix_mask(rt_len[idx]);
                    g_addr = (rt_prefix[idx] & m) | ($urandom & ~m);
                end else if ($urandom_range(1)) begin
                    g_addr = bases[$urandom_range(15)] ^ 32'($urandom_range(255));
                end else begin
                    g_addr = $urandom;
                end
                g_len = 6'($urandom);
            end
            send_item(g_op, g_addr, g_len, g_hop, g_port, 1'b0, '0);
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (route_q.size() != 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);

        if (errors == 0 && route_q.size() == 0) begin
            $display("lpm_route_table test passed");
        end else begin
            $display("lpm_route_table test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
